### design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### design/dqrhs_pkg.sv
package dqrhs_pkg;

	localparam int NODES = 6;
	localparam int ROWS = 5;
	localparam int LOG_STEPS = 16;
	localparam int EXP_STEPS = 24;
	localparam int QUO_BITS = 18;
	localparam logic [12:0] HILL_RESET = 13'd2560;

	typedef logic signed [21:0] coef_t;
	typedef coef_t [NODES-1:0] coef_row_t;

	localparam coef_row_t DMAT [ROWS] = '{
		'{22'sd36227, -22'sd81007, 22'sd117234, -22'sd262144, -22'sd153462, 22'sd343151},
		'{-22'sd50065, 22'sd117234, -22'sd212079, -22'sd22390, 22'sd262144, -22'sd94845},
		'{22'sd94845, -22'sd262144, 22'sd22390, 22'sd212079, -22'sd117234, 22'sd50065},
		'{-22'sd343151, 22'sd153462, 22'sd262144, -22'sd117234, 22'sd81007, -22'sd36227},
		'{-22'sd1114112, 22'sd1372604, -22'sd379378, 22'sd200260, -22'sd144910, 22'sd65536}
	};

	typedef struct packed {
		logic signed [15:0] s0;
		logic [14:0]        s5;
		logic               pos;
		logic               neg;
		logic [ROWS-1:0][23:0] der;
	} side_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] bt;
		rem = v;
		root = '0;
		bt = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (rem >= root + bt) begin
				rem = rem - (root + bt);
				root = (root >> 1) + bt;
			end else begin
				root = root >> 1;
			end
			bt = bt >> 2;
		end
		return root;
	endfunction

	function automatic logic [30:0] root_const(input int b);
		logic [63:0] rt;
		rt = 64'd2 << 30;
		for (int i = 1; i <= b; i++) begin
			rt = isqrt64(rt << 30);
		end
		return rt[30:0];
	endfunction

	function automatic logic [23:0] sat24(input logic signed [40:0] v);
		logic [23:0] r;
		if (v > 41'sd8388607) begin
			r = 24'h7FFFFF;
		end else if (v < -41'sd8388608) begin
			r = 24'h800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage

### design/delay_eq_chebyshev_rhs_unit.sv
// Chebyshev collocation right-hand side of the delayed feedback equation.
// Input channel: drive sample_0..sample_5 (signed Q4.12) with start high for
// one cycle; the beat is taken at the rising edge while busy is low. busy is
// always low, so a new beat may be offered in every cycle.
// Output channel: done is high for exactly one cycle with deriv_0..deriv_5
// (signed Q12.12, saturated) and domain_error. Results leave in beat order,
// one per cycle at most. The receiver cannot stall the block and need not.
// The pipeline holds sixteen squaring stages for the logarithm, twenty-four
// multiply stages for the power of two and eighteen quotient stages for the
// Hill division, each holding one 31-bit multiplier or one wide subtract.
// Configuration: cfg_data carries the Hill exponent (unsigned Q5.8) and is
// written when cfg_valid and cfg_ready are high; cfg_ready is always high.
// Write it only while no beat is in flight.
// Reset clears every valid bit in the pipeline and sets the exponent to 10.
`include "assert_macros.svh"

module delay_eq_chebyshev_rhs_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] sample_0,
	input  logic signed [15:0] sample_1,
	input  logic signed [15:0] sample_2,
	input  logic signed [15:0] sample_3,
	input  logic signed [15:0] sample_4,
	input  logic signed [15:0] sample_5,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [12:0]        cfg_data,
	output logic               done,
	output logic signed [23:0] deriv_0,
	output logic signed [23:0] deriv_1,
	output logic signed [23:0] deriv_2,
	output logic signed [23:0] deriv_3,
	output logic signed [23:0] deriv_4,
	output logic signed [23:0] deriv_5,
	output logic               domain_error
);

	localparam int LAST = 65;

	logic [12:0] hill_exp_q;
	logic        vld_s [1:LAST];

	logic signed [15:0] smp_s1 [dqrhs_pkg::NODES];
	logic signed [37:0] prod_s2 [dqrhs_pkg::ROWS][dqrhs_pkg::NODES];
	dqrhs_pkg::side_t   side_s [2:LAST-1];

	logic [30:0] y_s    [2:18];
	logic [15:0] frac_s [2:18];
	logic [3:0]  msb_s  [2:18];

	logic signed [34:0] t_s19;
	logic signed [5:0]  ip_s [20:44];
	logic [23:0]        fp_s [20:44];
	logic [30:0]        acc_s [20:44];
	logic [49:0]        den_s45;

	logic [49:0] rem_s [46:64];
	logic [49:0] dv_s  [46:64];
	logic [17:0] quo_s [46:64];

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hill_exp_q <= dqrhs_pkg::HILL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			hill_exp_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[1] <= start && !busy;
			for (int k = 2; k <= LAST; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		smp_s1[0] <= sample_0;
		smp_s1[1] <= sample_1;
		smp_s1[2] <= sample_2;
		smp_s1[3] <= sample_3;
		smp_s1[4] <= sample_4;
		smp_s1[5] <= sample_5;
	end

	// Stage 2: matrix products, and normalisation of the delayed sample.
	logic [3:0] msb_c;
	always_comb begin
		msb_c = '0;
		for (int i = 1; i < 15; i++) begin
			if (smp_s1[5][i]) begin
				msb_c = 4'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < dqrhs_pkg::ROWS; r++) begin
			for (int c = 0; c < dqrhs_pkg::NODES; c++) begin
				prod_s2[r][c] <= 38'(dqrhs_pkg::DMAT[r][c]) * 38'(smp_s1[c]);
			end
		end
		side_s[2].s0  <= smp_s1[0];
		side_s[2].s5  <= smp_s1[5][14:0];
		side_s[2].pos <= !smp_s1[5][15] && (smp_s1[5] != 16'sd0);
		side_s[2].neg <= smp_s1[5][15];
		side_s[2].der <= '0;
		y_s[2]    <= 31'(smp_s1[5][14:0]) << (5'd30 - 5'(msb_c));
		frac_s[2] <= '0;
		msb_s[2]  <= msb_c;
	end

	// Stage 3: row sums, rounded and saturated.
	logic [dqrhs_pkg::ROWS-1:0][23:0] der_c;
	always_comb begin
		logic signed [40:0] acc;
		for (int r = 0; r < dqrhs_pkg::ROWS; r++) begin
			acc = 41'sd32768;
			for (int c = 0; c < dqrhs_pkg::NODES; c++) begin
				acc = acc + 41'(prod_s2[r][c]);
			end
			der_c[r] = dqrhs_pkg::sat24(acc >>> 16);
		end
	end

	always_ff @(posedge clk) begin
		side_s[3] <= {side_s[2].s0, side_s[2].s5, side_s[2].pos, side_s[2].neg, der_c};
	end

	for (genvar k = 4; k <= LAST-1; k++) begin : g_side
		always_ff @(posedge clk) begin
			side_s[k] <= side_s[k-1];
		end
	end

	// Stages 3 to 18: one fraction bit of log2 per squaring.
	for (genvar k = 3; k <= 2 + dqrhs_pkg::LOG_STEPS; k++) begin : g_log
		logic [61:0] sq;
		assign sq = 62'(y_s[k-1]) * 62'(y_s[k-1]);
		always_ff @(posedge clk) begin
			msb_s[k] <= msb_s[k-1];
			if (sq[61]) begin
				y_s[k]    <= sq[61:31];
				frac_s[k] <= {frac_s[k-1][14:0], 1'b1};
			end else begin
				y_s[k]    <= sq[60:30];
				frac_s[k] <= {frac_s[k-1][14:0], 1'b0};
			end
		end
	end

	// Stage 19: exponent times logarithm. Stage 20: clamp and split.
	logic signed [20:0] lg_c;
	logic signed [34:0] tcl_c;
	assign lg_c = {5'($signed({1'b0, msb_s[18]}) - 6'sd12), frac_s[18]};
	always_comb begin
		if (t_s19 > 35'sd402653184) begin
			tcl_c = 35'sd402653184;
		end else if (t_s19 < -35'sd402653184) begin
			tcl_c = -35'sd402653184;
		end else begin
			tcl_c = t_s19;
		end
	end

	always_ff @(posedge clk) begin
		t_s19     <= 35'($signed({1'b0, hill_exp_q})) * 35'(lg_c);
		ip_s[20]  <= tcl_c[29:24];
		fp_s[20]  <= tcl_c[23:0];
		acc_s[20] <= 31'd1 << 30;
	end

	// Stages 21 to 44: product of the roots of two picked by the fraction bits.
	for (genvar b = 1; b <= dqrhs_pkg::EXP_STEPS; b++) begin : g_exp
		localparam logic [30:0] RT = dqrhs_pkg::root_const(b);
		logic [61:0] pr;
		assign pr = 62'(acc_s[20+b-1]) * 62'(RT);
		always_ff @(posedge clk) begin
			ip_s[20+b] <= ip_s[20+b-1];
			fp_s[20+b] <= fp_s[20+b-1];
			acc_s[20+b] <= fp_s[20+b-1][24-b] ? pr[60:30] : acc_s[20+b-1];
		end
	end

	// Stage 45: integer part as a shift; stage 46: division set-up.
	logic [54:0] shl_c;
	logic [48:0] p24_c;
	assign shl_c = 55'(acc_s[44]) << 5'(ip_s[44]);
	always_comb begin
		if (!ip_s[44][5]) begin
			p24_c = shl_c[54:6];
		end else begin
			p24_c = 49'(acc_s[44] >> 5'(6'sd6 - ip_s[44]));
		end
	end

	always_ff @(posedge clk) begin
		den_s45    <= (50'd1 << 24) + 50'(p24_c);
		rem_s[46]  <= (50'(side_s[45].s5) << 26) + (den_s45 >> 1);
		dv_s[46]   <= den_s45;
		quo_s[46]  <= '0;
	end

	// Stages 47 to 64: restoring division, one quotient bit a stage.
	for (genvar j = 0; j < dqrhs_pkg::QUO_BITS; j++) begin : g_div
		localparam int SH = dqrhs_pkg::QUO_BITS - 1 - j;
		logic [67:0] dsh;
		logic        ge;
		assign dsh = 68'(dv_s[46+j]) << SH;
		assign ge  = 68'(rem_s[46+j]) >= dsh;
		always_ff @(posedge clk) begin
			dv_s[47+j]  <= dv_s[46+j];
			rem_s[47+j] <= ge ? 50'(68'(rem_s[46+j]) - dsh) : rem_s[46+j];
			quo_s[47+j] <= quo_s[46+j] | (18'(ge) << SH);
		end
	end

	// Stage 65: output register.
	logic signed [40:0] d0_c;
	assign d0_c = 41'(side_s[64].pos ? quo_s[64] : 18'd0) - (41'(side_s[64].s0) <<< 1);

	always_ff @(posedge clk) begin
		deriv_0 <= dqrhs_pkg::sat24(d0_c);
		deriv_1 <= side_s[64].der[0];
		deriv_2 <= side_s[64].der[1];
		deriv_3 <= side_s[64].der[2];
		deriv_4 <= side_s[64].der[3];
		deriv_5 <= side_s[64].der[4];
		domain_error <= side_s[64].neg;
	end

	assign done = vld_s[LAST];

	`ASSERT_CLK(a_latency, clk, arst_n, start && !busy |-> ##65 done)
	`ASSERT_CLK(a_no_spurious, clk, arst_n, done |-> $past(start && !busy, 65))
	`ASSERT_CLK(a_domain_flag, clk, arst_n, done |-> domain_error == $past(sample_5[15], 65))

endmodule
